// ===== rtl/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Shared types and constants for the echo ranger: register map, the settings
// bundle, the per-tick result beat and the fixed-point distance constants.
// ----------------------------------------------------------------------------
package uer_pkg;

   // Default counter width for the tick counters.
   localparam int COUNT_WIDTH_DEF = 16;

   // Field widths fixed by the interface.
   localparam int TRIG_WIDTH = 8;
   localparam int TMO_WIDTH  = 16;
   localparam int DIST_WIDTH = 15;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   // Register indexes.
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_TRIGGER_TICKS = 2'd0,
      CSR_RISE_TIMEOUT  = 2'd1,
      CSR_ECHO_TIMEOUT  = 2'd2
   } csr_idx_type;

   // Register reset values.
   localparam logic [TRIG_WIDTH-1:0] TRIGGER_TICKS_RST = 8'd21;
   localparam logic [TMO_WIDTH-1:0]  RISE_TIMEOUT_RST  = 16'd5000;
   localparam logic [TMO_WIDTH-1:0]  ECHO_TIMEOUT_RST  = 16'd40000;

   // Distance = floor(ticks * 8 / 29), saturated at the 15-bit maximum.
   // The division by 29 is a multiply by ceil(2^25 / 29) and a shift; it is
   // exact for every product term below 2^25 / 18, which covers all ticks
   // below the saturation point.
   localparam int DIST_EXT_WIDTH  = 32;
   localparam int DIST_X_WIDTH    = 20;
   localparam int DIST_M_WIDTH    = 21;
   localparam int DIST_P_WIDTH    = DIST_X_WIDTH + DIST_M_WIDTH;
   localparam int DIST_SHIFT      = 25;
   localparam logic [DIST_M_WIDTH-1:0]   DIST_RECIP     = 21'd1157050;
   localparam logic [DIST_EXT_WIDTH-1:0] DIST_SAT_TICKS = 32'd118784;
   localparam logic [DIST_WIDTH-1:0]     DIST_MAX       = 15'h7FFF;

   // Settings handed to the sequencer.
   typedef struct packed {
      logic [TRIG_WIDTH-1:0] trigger_ticks;
      logic [TMO_WIDTH-1:0]  rise_timeout;
      logic [TMO_WIDTH-1:0]  echo_timeout;
   } cfg_type;

   // One result beat.
   typedef struct packed {
      logic                  trigger_out;
      logic                  busy_res;
      logic                  done_res;
      logic                  timed_out;
      logic [DIST_WIDTH-1:0] distance_q4;
   } rsp_type;

   // Measurement phases, one-hot.
   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_TRIG = 4'b0010,
      PH_RISE = 4'b0100,
      PH_HIGH = 4'b1000
   } phase_type;

endpackage

// ===== rtl/uer_dist.sv =====
// ----------------------------------------------------------------------------
// Echo width to distance converter
// Turns an echo width in ticks into centimetres, unsigned Q.4, truncated and
// saturated, using a reciprocal multiply in place of a divider.
// ----------------------------------------------------------------------------
module uer_dist
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic [COUNT_WIDTH-1:0] ticks,
   output logic [DIST_WIDTH-1:0]  distance_q4
);

   logic [DIST_EXT_WIDTH-1:0] ticks_ext;
   logic                      saturate;
   logic [DIST_X_WIDTH-1:0]   scaled;
   logic [DIST_P_WIDTH-1:0]   product;

   // Widen the count so that the saturation test works at any counter width.
   assign ticks_ext = DIST_EXT_WIDTH'(ticks);
   assign saturate  = (ticks_ext >= DIST_SAT_TICKS);

   // Below saturation the width fits 17 bits; times 8 gives 20 bits.
   assign scaled  = {ticks_ext[DIST_X_WIDTH-4:0], 3'b000};
   assign product = DIST_P_WIDTH'(scaled) * DIST_P_WIDTH'(DIST_RECIP);

   assign distance_q4 = saturate ? DIST_MAX
                                 : product[DIST_SHIFT+DIST_WIDTH-1:DIST_SHIFT];

endmodule

// ===== rtl/uer_seq.sv =====
// ----------------------------------------------------------------------------
// Measurement sequencer
// Holds the phase and the two tick counters and works out one result beat
// from the current state and one registered tick.
// ----------------------------------------------------------------------------
module uer_seq
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    start_req,
   input  logic    echo_level,
   input  cfg_type cfg,
   output rsp_type rsp
);

   localparam int CMP_W = (COUNT_WIDTH > TMO_WIDTH) ? COUNT_WIDTH : TMO_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] wait_count_ff, wait_count_in;
   logic [COUNT_WIDTH-1:0] echo_width_ff, echo_width_in;
   logic [COUNT_WIDTH-1:0] trig_count;
   logic [CMP_W-1:0]       trig_ext, rise_ext, echo_ext;
   logic [DIST_WIDTH-1:0]  distance;
   logic                   trig, done, tmo, use_dist;

   assign trig_ext = CMP_W'(cfg.trigger_ticks);
   assign rise_ext = CMP_W'(cfg.rise_timeout);
   assign echo_ext = CMP_W'(cfg.echo_timeout);

   // Trigger counter step, held at its maximum.
   assign trig_count = (wait_count_ff != CNT_MAX) ? wait_count_ff + CNT_ONE
                                                  : wait_count_ff;

   uer_dist #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dist (
      .ticks       (echo_width_ff),
      .distance_q4 (distance)
   );

   // Next state and result for the tick in hand.
   always_comb begin
      phase_in      = phase_ff;
      wait_count_in = wait_count_ff;
      echo_width_in = echo_width_ff;
      trig          = 1'b0;
      done          = 1'b0;
      tmo           = 1'b0;
      use_dist      = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start_req) begin
               trig = 1'b1;
               if (trig_ext <= CMP_W'(1)) begin
                  phase_in      = PH_RISE;
                  wait_count_in = '0;
               end else begin
                  phase_in      = PH_TRIG;
                  wait_count_in = CNT_ONE;
               end
            end
         end
         PH_TRIG: begin
            trig = 1'b1;
            if (CMP_W'(trig_count) >= trig_ext || trig_count == CNT_MAX) begin
               phase_in      = PH_RISE;
               wait_count_in = '0;
            end else begin
               wait_count_in = trig_count;
            end
         end
         PH_RISE: begin
            if (echo_level) begin
               phase_in      = PH_HIGH;
               echo_width_in = CNT_ONE;
               wait_count_in = '0;
            end else if (CMP_W'(wait_count_ff) >= rise_ext ||
                         wait_count_ff == CNT_MAX) begin
               done          = 1'b1;
               tmo           = 1'b1;
               phase_in      = PH_IDLE;
               wait_count_in = '0;
            end else begin
               wait_count_in = wait_count_ff + CNT_ONE;
            end
         end
         PH_HIGH: begin
            if (echo_level) begin
               if (CMP_W'(echo_width_ff) >= echo_ext ||
                   echo_width_ff == CNT_MAX) begin
                  done     = 1'b1;
                  tmo      = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  echo_width_in = echo_width_ff + CNT_ONE;
               end
            end else begin
               done     = 1'b1;
               use_dist = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in      = PH_IDLE;
            wait_count_in = '0;
         end
      endcase
   end

   assign rsp.trigger_out = trig;
   assign rsp.busy_res    = (phase_in != PH_IDLE);
   assign rsp.done_res    = done;
   assign rsp.timed_out   = tmo;
   assign rsp.distance_q4 = use_dist ? distance : '0;

   // State moves only when a tick passes into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         wait_count_ff <= '0;
         echo_width_ff <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         wait_count_ff <= wait_count_in;
         echo_width_ff <= echo_width_in;
      end
   end

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Time-of-flight ranging from one echo pulse: trigger pulse, bounded wait for
// the echo rise, bounded echo width count and conversion to centimetres.
//
//   Channel  Direction  Handshake        Beat
//   req_     in         valid / ready    one tick: start request, echo level
//   rsp_     out        valid / ready    one result per tick
//   csr_     in         write enable     register index and write data
//
// One tick is taken per cycle while the result side is not stalled; a result
// leaves after its tick is taken, through an input register and a result register.
// The sequencer state advances only as a tick moves into the result register.
// A stalled result register holds its beat while the input register still
// takes one more tick; further ticks wait on req_ready.
// Reset restores the register defaults and puts the sequencer in idle.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Tick input
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_start_req,
   input  logic                      req_echo_level,
   // Result output
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_trigger_out,
   output logic                      rsp_busy_res,
   output logic                      rsp_done_res,
   output logic                      rsp_timed_out,
   output logic [DIST_WIDTH-1:0]     rsp_distance_q4,
   // Register writes
   input  logic                      csr_we,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    in_valid_ff, in_valid_in;
   logic    in_start_ff, in_echo_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   rsp_type seq_rsp;
   logic    req_fire, out_free, advance;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= TRIGGER_TICKS_RST;
         cfg_ff.rise_timeout  <= RISE_TIMEOUT_RST;
         cfg_ff.echo_timeout  <= ECHO_TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRIGGER_TICKS: cfg_ff.trigger_ticks <= csr_wdata[TRIG_WIDTH-1:0];
            CSR_RISE_TIMEOUT:  cfg_ff.rise_timeout  <= csr_wdata;
            CSR_ECHO_TIMEOUT:  cfg_ff.echo_timeout  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Handshake: the input register moves on whenever the result register is
   // free or being emptied this cycle.
   assign out_free     = !out_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ready    = !in_valid_ff || out_free;
   assign req_fire     = req_valid && req_ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_start_ff <= req_start_req;
         in_echo_ff  <= req_echo_level;
      end
   end

   uer_seq #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .start_req  (in_start_ff),
      .echo_level (in_echo_ff),
      .cfg        (cfg_ff),
      .rsp        (seq_rsp)
   );

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= seq_rsp;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_trigger_out = out_ff.trigger_out;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_done_res    = out_ff.done_res;
   assign rsp_timed_out   = out_ff.timed_out;
   assign rsp_distance_q4 = out_ff.distance_q4;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Echo ranger testbench
// Drives one tick per input beat into the ranger and checks every result
// beat against an in-bench predictor of the trigger, rise wait and echo width
// sequence. A short directed run covers zero lengths, zero timeouts and
// starts while busy. Random phases then sweep the register settings with
// mostly well-formed measurements, bursts of noise, random idling on both
// channels and one long result stall.
// ----------------------------------------------------------------------------
module tb
   import uer_pkg::*;
;

   localparam int unsigned TICK_COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_TARGET = 1300;
   localparam int HOLD_AFTER_BEATS = 300;
   localparam int HOLD_CYCLES = 400;

   // Predicts the result beat of every accepted tick and holds the beats
   // still to come, oldest first.
   class ranging_scoreboard;
      cfg_type     cfg;
      phase_type   phase;
      int unsigned wait_cnt;
      int unsigned width_cnt;
      rsp_type     pending_results[$];
      int          errors;

      function new();
         cfg.trigger_ticks = TRIGGER_TICKS_RST;
         cfg.rise_timeout  = RISE_TIMEOUT_RST;
         cfg.echo_timeout  = ECHO_TIMEOUT_RST;
         phase     = PH_IDLE;
         wait_cnt  = 0;
         width_cnt = 0;
         errors    = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [CSR_DATA_WIDTH-1:0] val);
         case (idx)
            CSR_TRIGGER_TICKS: cfg.trigger_ticks = val[TRIG_WIDTH-1:0];
            CSR_RISE_TIMEOUT:  cfg.rise_timeout  = val;
            CSR_ECHO_TIMEOUT:  cfg.echo_timeout  = val;
            default: ;
         endcase
      endfunction

      // Distance in Q.4 centimetres, truncated and saturated.
      function logic [DIST_WIDTH-1:0] ticks_to_q4(int unsigned ticks);
         longint unsigned q;
         q = (longint'(ticks) * 16) / 58;
         if (q > DIST_MAX)
            q = DIST_MAX;
         return q[DIST_WIDTH-1:0];
      endfunction

      function void note_tick(logic start, logic echo);
         rsp_type r;
         r = '0;
         case (phase)
            PH_IDLE: begin
               if (start) begin
                  r.trigger_out = 1'b1;
                  wait_cnt = 1;
                  phase = PH_TRIG;
                  if (wait_cnt >= cfg.trigger_ticks) begin
                     phase = PH_RISE;
                     wait_cnt = 0;
                  end
               end
            end
            PH_TRIG: begin
               r.trigger_out = 1'b1;
               if (wait_cnt < TICK_COUNT_MAX)
                  wait_cnt++;
               if (wait_cnt >= cfg.trigger_ticks || wait_cnt >= TICK_COUNT_MAX) begin
                  phase = PH_RISE;
                  wait_cnt = 0;
               end
            end
            PH_RISE: begin
               if (echo) begin
                  phase = PH_HIGH;
                  width_cnt = 1;
                  wait_cnt = 0;
               end else if (wait_cnt >= cfg.rise_timeout || wait_cnt >= TICK_COUNT_MAX) begin
                  r.done_res  = 1'b1;
                  r.timed_out = 1'b1;
                  phase = PH_IDLE;
                  wait_cnt = 0;
               end else begin
                  wait_cnt++;
               end
            end
            default: begin
               // Echo high: count its width, or finish on the falling edge.
               if (echo) begin
                  if (width_cnt >= cfg.echo_timeout || width_cnt >= TICK_COUNT_MAX) begin
                     r.done_res  = 1'b1;
                     r.timed_out = 1'b1;
                     phase = PH_IDLE;
                  end else begin
                     width_cnt++;
                  end
               end else begin
                  r.done_res = 1'b1;
                  r.distance_q4 = ticks_to_q4(width_cnt);
                  phase = PH_IDLE;
               end
            end
         endcase
         r.busy_res = (phase != PH_IDLE);
         pending_results.push_back(r);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with none expected, got %h", $time, got);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("trigger_out", want.trigger_out, got.trigger_out);
         compare_field("busy_res", want.busy_res, got.busy_res);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("timed_out", want.timed_out, got.timed_out);
         compare_field("distance_q4", want.distance_q4, got.distance_q4);
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_start_req = 1'b0;
   logic                      req_echo_level = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_trigger_out;
   logic                      rsp_busy_res;
   logic                      rsp_done_res;
   logic                      rsp_timed_out;
   logic [DIST_WIDTH-1:0]     rsp_distance_q4;
   logic                      csr_we = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   ranging_scoreboard sb = new();

   int cycle_count = 0;
   int items_sent = 0;
   int rsp_count = 0;
   int stall_left = 0;
   bit held_off = 1'b0;
   bit calm = 1'b0;

   ultrasonic_echo_ranger u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_req   (req_start_req),
      .req_echo_level  (req_echo_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_trigger_out (rsp_trigger_out),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_done_res    (rsp_done_res),
      .rsp_timed_out   (rsp_timed_out),
      .rsp_distance_q4 (rsp_distance_q4),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #10 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL ultrasonic_echo_ranger");
         $finish;
      end
   end

   // Idle length for either side: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Result side: random stalls, plus one long hold-off once traffic is flowing.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!held_off && rsp_count >= HOLD_AFTER_BEATS) begin
         held_off = 1'b1;
         stall_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin : rsp_monitor
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_trigger_out, rsp_busy_res, rsp_done_res, rsp_timed_out, rsp_distance_q4};
         sb.check_result(got);
         rsp_count <= rsp_count + 1;
      end
   end

   // Offers one tick beat; entered and left at a falling edge.
   task automatic send_tick(input logic start, input logic echo);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_start_req  <= start;
      req_echo_level <= echo;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(start, echo);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_WIDTH-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(negedge clock);
   endtask

   // Upper bits of the trigger write are junk and must be dropped.
   task automatic apply_settings(input cfg_type c);
      write_reg(CSR_TRIGGER_TICKS, {8'($urandom), c.trigger_ticks});
      write_reg(CSR_RISE_TIMEOUT, c.rise_timeout);
      write_reg(CSR_ECHO_TIMEOUT, c.echo_timeout);
      csr_we <= 1'b0;
   endtask

   // Drains all results and walks any measurement still running back to idle,
   // so that register writes never land mid-measurement.
   task automatic settle();
      forever begin
         req_valid <= 1'b0;
         while (sb.pending() != 0)
            @(posedge clock);
         @(negedge clock);
         if (sb.phase == PH_IDLE)
            break;
         send_tick(1'b0, sb.phase == PH_RISE);
      end
   endtask

   function automatic logic stray_start();
      return ($urandom_range(0, 3) == 0);
   endfunction

   // One well-formed measurement with random lengths; the rise wait sometimes
   // overruns its limit, and the echo sometimes overruns its limit.
   task automatic run_measurement();
      int trig_len;
      int rise_lim;
      int echo_lim;
      int low_len;
      int high_len;
      trig_len = (sb.cfg.trigger_ticks == 0) ? 1 : sb.cfg.trigger_ticks;
      rise_lim = (sb.cfg.rise_timeout > 20) ? 20 : sb.cfg.rise_timeout;
      echo_lim = (sb.cfg.echo_timeout > 40) ? 40 : sb.cfg.echo_timeout;
      send_tick(1'b1, 1'($urandom));
      repeat (trig_len - 1) send_tick(stray_start(), 1'($urandom));
      low_len = $urandom_range(0, rise_lim + 1);
      repeat (low_len) send_tick(stray_start(), 1'b0);
      // A wait longer than the limit has already ended the measurement.
      if (low_len > sb.cfg.rise_timeout)
         return;
      if ($urandom_range(0, 19) == 0 && sb.cfg.echo_timeout > 600)
         high_len = $urandom_range(41, 600);
      else
         high_len = $urandom_range(1, echo_lim + 2);
      repeat (high_len) send_tick(stray_start(), 1'b1);
      send_tick(stray_start(), 1'b0);
   endtask

   // Mostly measurements, with some bursts of noise, then back to idle.
   task automatic stimulate(input int span);
      int first;
      calm = ($urandom_range(0, 3) == 0);
      first = items_sent;
      while (items_sent - first < span) begin
         if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 20))
               send_tick($urandom_range(0, 7) == 0, 1'($urandom));
         else
            run_measurement();
         repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom));
      end
      settle();
   endtask

   function automatic cfg_type pick_settings(int n);
      cfg_type c;
      int r;
      case (n)
         0: c = '{8'd255, 16'd65535, 16'd65535};
         1: c = '{8'd1, 16'd1, 16'd1};
         2: c = '{8'd0, 16'd65535, 16'd0};
         default: begin
            r = $urandom_range(0, 99);
            c.trigger_ticks = (r < 10) ? 8'd0 : (r < 14) ? 8'd255 : 8'($urandom_range(1, 6));
            r = $urandom_range(0, 99);
            c.rise_timeout = (r < 10) ? 16'd0 : (r < 20) ? 16'd65535 :
                             16'($urandom_range(1, 12));
            r = $urandom_range(0, 99);
            c.echo_timeout = (r < 10) ? 16'd0 : (r < 25) ? 16'd65535 :
                             16'($urandom_range(1, 40));
         end
      endcase
      return c;
   endfunction

   initial begin : stimulus
      bit [1:0] zero_seq [9];
      bit [1:0] short_seq [16];
      cfg_type c;
      int n;
      // Beat codes: start request in bit 1, echo level in bit 0.
      // Zero lengths: idle echo, start, rise timeout with a start while busy,
      // echo timeout at the second high tick, and a one-tick echo.
      zero_seq = '{2'b01, 2'b11, 2'b10, 2'b10, 2'b01, 2'b01,
                   2'b10, 2'b01, 2'b00};
      // Three-tick trigger, two low ticks, four high ticks for a non-zero
      // distance, then a rise wait that overruns by one tick.
      short_seq = '{2'b10, 2'b11, 2'b00, 2'b00, 2'b00, 2'b01,
                    2'b01, 2'b01, 2'b01, 2'b00, 2'b10, 2'b01,
                    2'b01, 2'b00, 2'b00, 2'b00};
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset settings first.
      stimulate(60);

      c = '{8'd0, 16'd0, 16'd0};
      apply_settings(c);
      foreach (zero_seq[i]) send_tick(zero_seq[i][1], zero_seq[i][0]);
      settle();

      c = '{8'd3, 16'd2, 16'd5};
      apply_settings(c);
      foreach (short_seq[i]) send_tick(short_seq[i][1], short_seq[i][0]);
      settle();

      // Random phases over a spread of settings.
      n = 0;
      while (items_sent < ITEM_TARGET) begin
         apply_settings(pick_settings(n));
         stimulate($urandom_range(80, 160));
         n++;
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS ultrasonic_echo_ranger");
      else
         $display("FAIL ultrasonic_echo_ranger");
      $finish;
   end

endmodule
